/* hw/rtl/char_lcd_nibble_write_sequencer_macros.svh */
// Assertion macros used by the LCD write sequencer checker.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// check outside reset
`define CLCD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check through reset as well
`define CLCD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/clcd_pkg.sv */
// Types, codes and constant tables for the character LCD write sequencer.
`timescale 1ns / 1ps
package clcd_pkg;

  localparam int unsigned HOLD_W = 17;
  localparam int unsigned CFG_W  = 16;

  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_DATA   = 3'd2;
  localparam logic [2:0] MODE_CURSOR = 3'd3;
  localparam logic [2:0] MODE_HOME   = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [2:0] REG_PULSE     = 3'd0;
  localparam logic [2:0] REG_SETTLE    = 3'd1;
  localparam logic [2:0] REG_POWER     = 3'd2;
  localparam logic [2:0] REG_LONG      = 3'd3;
  localparam logic [2:0] REG_INIT_ONE  = 3'd4;
  localparam logic [2:0] REG_INIT_TWO  = 3'd5;

  localparam logic [CFG_W-1:0] RST_PULSE    = 16'd10;
  localparam logic [CFG_W-1:0] RST_SETTLE   = 16'd100;
  localparam logic [CFG_W-1:0] RST_POWER    = 16'd40000;
  localparam logic [CFG_W-1:0] RST_LONG     = 16'd2000;
  localparam logic [CFG_W-1:0] RST_INIT_ONE = 16'd5000;
  localparam logic [CFG_W-1:0] RST_INIT_TWO = 16'd150;

  localparam logic [7:0] BYTE_HOME  = 8'h02;
  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] ROW1_BASE  = 8'h80;
  localparam logic [7:0] ROW2_BASE  = 8'hC0;
  localparam logic [1:0] ROW_ONE    = 2'd1;
  localparam logic [1:0] ROW_TWO    = 2'd2;

  localparam logic [4:0] INIT_LAST_STEP = 5'd24;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd4;
  localparam logic [4:0] BYTE_FIRST_STEP = 5'd1;
  localparam logic [3:0] INIT_NIB_FIRST = 4'd0;
  localparam logic [3:0] INIT_NIB_SECOND = 4'd1;
  localparam logic [3:0] INIT_NIB_CLEAR = 4'd9;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } seq_state_t;

  typedef enum logic [1:0] {
    BASE_PULSE,
    BASE_SETTLE,
    BASE_POWER
  } base_sel_t;

  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_FIRST,
    EXTRA_SECOND,
    EXTRA_LONG
  } extra_sel_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [7:0] column;
  } req_t;

  typedef struct packed {
    logic              reg_select;
    logic              read_write;
    logic [3:0]        data_nibble;
    logic              enable_pin;
    logic [HOLD_W-1:0] hold_us;
    logic              last_state;
  } pin_t;

  typedef struct packed {
    logic [2:0]       reg_index;
    logic [CFG_W-1:0] reg_value;
  } cfg_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0] pulse;
    logic [CFG_W-1:0] settle;
    logic [CFG_W-1:0] power;
    logic [CFG_W-1:0] long_wait;
    logic [CFG_W-1:0] init_one;
    logic [CFG_W-1:0] init_two;
  } cfg_regs_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] data_nibble;
    logic       enable_pin;
    base_sel_t  base_sel;
    extra_sel_t extra_sel;
    logic       last_state;
  } step_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd7:             nib = 4'hE;
      4'd9:             nib = 4'h1;
      4'd11:            nib = 4'h6;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

/* hw/rtl/clcd_chan_if.sv */
// Valid/ready channel interface carrying one word of a given payload type.
`timescale 1ns / 1ps
interface clcd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/clcd_cfg_regs.sv */
// Configuration register file holding the six microsecond hold settings.
`timescale 1ns / 1ps
module clcd_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  clcd_pkg::cfg_wr_t  wr,
  output clcd_pkg::cfg_regs_t regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pulse     <= clcd_pkg::RST_PULSE;
      regs.settle    <= clcd_pkg::RST_SETTLE;
      regs.power     <= clcd_pkg::RST_POWER;
      regs.long_wait <= clcd_pkg::RST_LONG;
      regs.init_one  <= clcd_pkg::RST_INIT_ONE;
      regs.init_two  <= clcd_pkg::RST_INIT_TWO;
    end else if (wr_en) begin
      unique case (wr.reg_index)
        clcd_pkg::REG_PULSE:    regs.pulse     <= wr.reg_value;
        clcd_pkg::REG_SETTLE:   regs.settle    <= wr.reg_value;
        clcd_pkg::REG_POWER:    regs.power     <= wr.reg_value;
        clcd_pkg::REG_LONG:     regs.long_wait <= wr.reg_value;
        clcd_pkg::REG_INIT_ONE: regs.init_one  <= wr.reg_value;
        clcd_pkg::REG_INIT_TWO: regs.init_two  <= wr.reg_value;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/clcd_hold_unit.sv */
// Shared hold-time adder: base hold plus any extra wait for one pin state.
`timescale 1ns / 1ps
module clcd_hold_unit (
  input  clcd_pkg::cfg_regs_t        regs,
  input  clcd_pkg::base_sel_t        base_sel,
  input  clcd_pkg::extra_sel_t       extra_sel,
  output logic [clcd_pkg::HOLD_W-1:0] hold
);

  logic [clcd_pkg::CFG_W-1:0] base;
  logic [clcd_pkg::CFG_W-1:0] extra;

  always_comb begin
    unique case (base_sel)
      clcd_pkg::BASE_PULSE:  base = regs.pulse;
      clcd_pkg::BASE_SETTLE: base = regs.settle;
      clcd_pkg::BASE_POWER:  base = regs.power;
      default:               base = '0;
    endcase
    unique case (extra_sel)
      clcd_pkg::EXTRA_NONE:   extra = '0;
      clcd_pkg::EXTRA_FIRST:  extra = regs.init_one;
      clcd_pkg::EXTRA_SECOND: extra = regs.init_two;
      clcd_pkg::EXTRA_LONG:   extra = regs.long_wait;
      default:                extra = '0;
    endcase
  end

  assign hold = {1'b0, base} + {1'b0, extra};

endmodule

/* hw/rtl/clcd_step_seq.sv */
// Step sequencer: walks the pin states of one request, one state per advance.
`timescale 1ns / 1ps
module clcd_step_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  clcd_pkg::req_t  req,
  output logic            req_ready,
  input  logic            advance,
  output logic            step_valid,
  output clcd_pkg::step_t step
);

  clcd_pkg::seq_state_t state, state_next;
  logic [4:0] st, st_next;
  logic [4:0] last_st, last_st_next;
  logic       is_init, is_init_next;
  logic       rs, rs_next;
  logic       long_wait, long_wait_next;
  logic [7:0] byte_q, byte_q_next;

  logic [4:0] pos;
  logic [3:0] nib_idx;
  logic       en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    st        <= st_next;
    last_st   <= last_st_next;
    is_init   <= is_init_next;
    rs        <= rs_next;
    long_wait <= long_wait_next;
    byte_q    <= byte_q_next;
  end

  assign pos     = st - 5'd1;
  assign nib_idx = pos[4:1];
  assign en      = ~pos[0];

  always_comb begin
    state_next     = state;
    st_next        = st;
    last_st_next   = last_st;
    is_init_next   = is_init;
    rs_next        = rs;
    long_wait_next = long_wait;
    byte_q_next    = byte_q;
    req_ready      = 1'b0;
    step_valid     = 1'b0;

    step.reg_select  = rs;
    step.enable_pin  = en;
    step.base_sel    = en ? clcd_pkg::BASE_PULSE : clcd_pkg::BASE_SETTLE;
    step.extra_sel   = clcd_pkg::EXTRA_NONE;
    step.last_state  = (st == last_st);
    if (is_init) begin
      step.data_nibble = clcd_pkg::init_nibble(nib_idx);
    end else begin
      step.data_nibble = nib_idx[0] ? byte_q[3:0] : byte_q[7:4];
    end

    if (is_init && st == 5'd0) begin
      step.reg_select  = 1'b0;
      step.data_nibble = 4'h0;
      step.enable_pin  = 1'b0;
      step.base_sel    = clcd_pkg::BASE_POWER;
    end else if (!en) begin
      if (is_init) begin
        if (nib_idx == clcd_pkg::INIT_NIB_FIRST) begin
          step.extra_sel = clcd_pkg::EXTRA_FIRST;
        end else if (nib_idx == clcd_pkg::INIT_NIB_SECOND) begin
          step.extra_sel = clcd_pkg::EXTRA_SECOND;
        end else if (nib_idx == clcd_pkg::INIT_NIB_CLEAR) begin
          step.extra_sel = clcd_pkg::EXTRA_LONG;
        end
      end else if (long_wait && nib_idx[0]) begin
        step.extra_sel = clcd_pkg::EXTRA_LONG;
      end
    end

    unique case (state)
      clcd_pkg::S_IDLE: begin
        req_ready      = ~rst;
        st_next        = clcd_pkg::BYTE_FIRST_STEP;
        last_st_next   = clcd_pkg::BYTE_LAST_STEP;
        is_init_next   = 1'b0;
        rs_next        = 1'b0;
        long_wait_next = 1'b0;
        byte_q_next    = req.byte_value;
        if (req_valid) begin
          case (req.mode)
            clcd_pkg::MODE_INIT: begin
              st_next      = 5'd0;
              last_st_next = clcd_pkg::INIT_LAST_STEP;
              is_init_next = 1'b1;
              state_next   = clcd_pkg::S_RUN;
            end
            clcd_pkg::MODE_CMD: begin
              state_next = clcd_pkg::S_RUN;
            end
            clcd_pkg::MODE_DATA: begin
              rs_next    = 1'b1;
              state_next = clcd_pkg::S_RUN;
            end
            clcd_pkg::MODE_CURSOR: begin
              if (req.row == clcd_pkg::ROW_ONE) begin
                byte_q_next = (req.column - 8'd1) | clcd_pkg::ROW1_BASE;
                state_next  = clcd_pkg::S_RUN;
              end else if (req.row == clcd_pkg::ROW_TWO) begin
                byte_q_next = (req.column - 8'd1) | clcd_pkg::ROW2_BASE;
                state_next  = clcd_pkg::S_RUN;
              end
            end
            clcd_pkg::MODE_HOME: begin
              byte_q_next    = clcd_pkg::BYTE_HOME;
              long_wait_next = 1'b1;
              state_next     = clcd_pkg::S_RUN;
            end
            clcd_pkg::MODE_CLEAR: begin
              byte_q_next    = clcd_pkg::BYTE_CLEAR;
              long_wait_next = 1'b1;
              state_next     = clcd_pkg::S_RUN;
            end
            default: ;
          endcase
        end
      end
      clcd_pkg::S_RUN: begin
        step_valid = 1'b1;
        if (advance) begin
          st_next = st + 5'd1;
          if (st == last_st) begin
            state_next = clcd_pkg::S_IDLE;
          end
        end
      end
      default: state_next = clcd_pkg::S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer.
//
//   channel  dir  payload                                          word
//   req      in   mode, byte_value, row, column                     one request
//   pin      out  reg_select, read_write, data_nibble, enable_pin,  one pin state
//                 hold_us, last_state
//   cfg      in   reg_index, reg_value                              one register write
//
// A request is taken while the sequencer is idle; then, unless the pin output stalls,
// one pin state a cycle leaves the shared hold adder for the output register:
// 4 states for a byte request, 25 for init. The next request is taken only after
// the last state of the previous one; requests that produce no states are absorbed.
// rst (synchronous) restores the register reset values and empties the output.
// A stalled pin output holds the sequencer; req and cfg are not ready during rst.
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer (
  input logic          clk,
  input logic          rst,
  clcd_chan_if.sink    req,
  clcd_chan_if.source  pin,
  clcd_chan_if.sink    cfg
);

  clcd_pkg::cfg_regs_t regs;
  clcd_pkg::step_t     step;
  logic                step_valid;
  logic                pin_free;
  logic [clcd_pkg::HOLD_W-1:0] hold;

  assign cfg.ready = ~rst;
  assign pin_free  = ~pin.valid | pin.ready;

  clcd_cfg_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid),
    .wr    (cfg.data),
    .regs  (regs)
  );

  clcd_step_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req        (req.data),
    .req_ready  (req.ready),
    .advance    (pin_free),
    .step_valid (step_valid),
    .step       (step)
  );

  clcd_hold_unit u_hold (
    .regs      (regs),
    .base_sel  (step.base_sel),
    .extra_sel (step.extra_sel),
    .hold      (hold)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pin.valid <= 1'b0;
    end else if (pin_free) begin
      pin.valid <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_free && step_valid) begin
      pin.data.reg_select  <= step.reg_select;
      pin.data.read_write  <= 1'b0;
      pin.data.data_nibble <= step.data_nibble;
      pin.data.enable_pin  <= step.enable_pin;
      pin.data.hold_us     <= hold;
      pin.data.last_state  <= step.last_state;
    end
  end

endmodule

/* hw/rtl/clcd_checker.sv */
// Port-level checker for the LCD write sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_macros.svh"
module clcd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           pin_valid,
  input logic           pin_ready,
  input clcd_pkg::pin_t pin_data
);

  `CLCD_ASSERT(a_rw_low, pin_valid |-> !pin_data.read_write, "RW driven high")
  `CLCD_ASSERT(a_busy_mid_run, pin_valid && !pin_data.last_state |-> !req_ready, "request taken mid-run")
  `CLCD_ASSERT(a_en_not_last, pin_valid && pin_data.enable_pin |-> !pin_data.last_state, "run ends with EN high")
  `CLCD_ASSERT(a_stall_hold, pin_valid && !pin_ready |=> pin_valid && $stable(pin_data), "stalled word changed")
  `CLCD_ASSERT_RST(a_rst_empty, rst |=> !pin_valid, "output valid after reset")

endmodule

bind char_lcd_nibble_write_sequencer clcd_checker u_clcd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .pin_valid (pin.valid),
  .pin_ready (pin.ready),
  .pin_data  (pin.data)
);

/* bench/char_lcd_nibble_write_sequencer_test.sv */
// Self-checking testbench for the 4-bit character LCD write sequencer.
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer_test;

  localparam logic [2:0] MODE_SPARE_A    = 3'd6;
  localparam logic [2:0] MODE_SPARE_B    = 3'd7;
  localparam logic [7:0] BYTE_FUNC_SET   = 8'h28;
  localparam logic [7:0] BYTE_DISPLAY_ON = 8'h0E;
  localparam logic [7:0] BYTE_ENTRY_MODE = 8'h06;
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
  localparam int NUM_REGS        = 6;
  localparam int NUM_DIRECTED    = 20;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct {
    clcd_pkg::req_t       req;
    bit                   typed;
    int                   n;
    clcd_pkg::pin_t [0:3] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clcd_chan_if #(.T(clcd_pkg::req_t))    req_ch ();
  clcd_chan_if #(.T(clcd_pkg::pin_t))    pin_ch ();
  clcd_chan_if #(.T(clcd_pkg::cfg_wr_t)) cfg_ch ();

  char_lcd_nibble_write_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .pin (pin_ch),
    .cfg (cfg_ch)
  );

  clcd_pkg::cfg_regs_t cfg_shadow;
  clcd_pkg::pin_t      pin_states_due [$];
  int        fail_count  = 0;
  int        quiet_left  = 0;
  int        stall_left  = 0;
  int        burst_left  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic clcd_pkg::pin_t pin_state(logic rs, logic [3:0] nib, logic en,
                                               logic [clcd_pkg::HOLD_W-1:0] hold,
                                               logic last);
    clcd_pkg::pin_t p;
    p.reg_select  = rs;
    p.read_write  = 1'b0;
    p.data_nibble = nib;
    p.enable_pin  = en;
    p.hold_us     = hold;
    p.last_state  = last;
    return p;
  endfunction

  function automatic void push_nibble(logic rs, logic [3:0] nib,
                                      logic [clcd_pkg::CFG_W-1:0] extra);
    pin_states_due.push_back(pin_state(rs, nib, 1'b1,
                                       clcd_pkg::HOLD_W'(cfg_shadow.pulse), 1'b0));
    pin_states_due.push_back(pin_state(rs, nib, 1'b0,
                                       clcd_pkg::HOLD_W'(cfg_shadow.settle) +
                                       clcd_pkg::HOLD_W'(extra), 1'b0));
  endfunction

  function automatic void push_byte(logic rs, logic [7:0] b,
                                    logic [clcd_pkg::CFG_W-1:0] extra);
    push_nibble(rs, b[7:4], '0);
    push_nibble(rs, b[3:0], extra);
  endfunction

  function automatic int predict_pin_states(clcd_pkg::req_t r);
    int             base;
    clcd_pkg::pin_t tail;
    logic [7:0]     addr;
    base = pin_states_due.size();
    addr = r.column - 8'd1;
    case (r.mode)
      clcd_pkg::MODE_INIT: begin
        pin_states_due.push_back(pin_state(1'b0, 4'h0, 1'b0,
                                           clcd_pkg::HOLD_W'(cfg_shadow.power), 1'b0));
        push_nibble(1'b0, NIB_WAKE, cfg_shadow.init_one);
        push_nibble(1'b0, NIB_WAKE, cfg_shadow.init_two);
        push_nibble(1'b0, NIB_WAKE, '0);
        push_nibble(1'b0, NIB_FOUR_BIT, '0);
        push_byte(1'b0, BYTE_FUNC_SET, '0);
        push_byte(1'b0, BYTE_DISPLAY_ON, '0);
        push_byte(1'b0, clcd_pkg::BYTE_CLEAR, cfg_shadow.long_wait);
        push_byte(1'b0, BYTE_ENTRY_MODE, '0);
      end
      clcd_pkg::MODE_CMD:  push_byte(1'b0, r.byte_value, '0);
      clcd_pkg::MODE_DATA: push_byte(1'b1, r.byte_value, '0);
      clcd_pkg::MODE_CURSOR: begin
        if (r.row == clcd_pkg::ROW_ONE) push_byte(1'b0, addr | clcd_pkg::ROW1_BASE, '0);
        else if (r.row == clcd_pkg::ROW_TWO) push_byte(1'b0, addr | clcd_pkg::ROW2_BASE, '0);
      end
      clcd_pkg::MODE_HOME:  push_byte(1'b0, clcd_pkg::BYTE_HOME, cfg_shadow.long_wait);
      clcd_pkg::MODE_CLEAR: push_byte(1'b0, clcd_pkg::BYTE_CLEAR, cfg_shadow.long_wait);
      default: ;
    endcase
    if (pin_states_due.size() > base) begin
      tail = pin_states_due.pop_back();
      tail.last_state = 1'b1;
      pin_states_due.push_back(tail);
    end
    return pin_states_due.size() - base;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // hold the request valid until taken, after an optional random gap
  task automatic send_req(input clcd_pkg::req_t r, input bit typed, input int n,
                          input clcd_pkg::pin_t [0:3] st, output int states);
    int gap;
    int pick;
    gap = 0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      pick = $urandom_range(99);
      if (pick < 5) quiet_left = $urandom_range(40, 10);
      if (pick >= 97) gap = $urandom_range(50, 20);
      else if (pick >= 88) gap = $urandom_range(10, 4);
      else if (pick >= 55) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (typed) begin
      for (int k = 0; k < n; k++) pin_states_due.push_back(st[k]);
      states = n;
    end else begin
      states = predict_pin_states(r);
    end
  endtask

  task automatic drain_pins();
    req_ch.valid <= 1'b0;
    while (pin_states_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input clcd_pkg::cfg_regs_t v);
    clcd_pkg::cfg_wr_t w;
    for (int i = 0; i < NUM_REGS; i++) begin
      w.reg_index = 3'(i);
      case (w.reg_index)
        clcd_pkg::REG_PULSE:    w.reg_value = v.pulse;
        clcd_pkg::REG_SETTLE:   w.reg_value = v.settle;
        clcd_pkg::REG_POWER:    w.reg_value = v.power;
        clcd_pkg::REG_LONG:     w.reg_value = v.long_wait;
        clcd_pkg::REG_INIT_ONE: w.reg_value = v.init_one;
        default:                w.reg_value = v.init_two;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= w;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cfg_shadow = v;
  endtask

  always @(posedge clk) begin
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      pin_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      pin_ch.ready <= 1'b0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) burst_left = $urandom_range(60, 20);
      else if (pick < 14) stall_left = $urandom_range(40, 10);
      else if (pick < 40) stall_left = $urandom_range(3, 1);
      pin_ch.ready <= (pick < 10 || pick >= 40);
    end
  end

  always @(posedge clk) begin
    clcd_pkg::pin_t want;
    if (!rst && pin_ch.valid && pin_ch.ready) begin
      if (pin_states_due.size() == 0) begin
        fail_count++;
        $display("%0t: pin word %h arrived with nothing expected", $time, pin_ch.data);
      end else begin
        want = pin_states_due.pop_front();
        check_field("reg_select",  32'(want.reg_select),  32'(pin_ch.data.reg_select));
        check_field("read_write",  32'(want.read_write),  32'(pin_ch.data.read_write));
        check_field("data_nibble", 32'(want.data_nibble), 32'(pin_ch.data.data_nibble));
        check_field("enable_pin",  32'(want.enable_pin),  32'(pin_ch.data.enable_pin));
        check_field("hold_us",     32'(want.hold_us),     32'(pin_ch.data.hold_us));
        check_field("last_state",  32'(want.last_state),  32'(pin_ch.data.last_state));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    dir_row_t            dir_tab [NUM_DIRECTED];
    clcd_pkg::req_t      r;
    clcd_pkg::cfg_regs_t v;
    int                  states;
    int                  produced;
    int                  pick;

    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    pin_ch.ready = 1'b0;
    cfg_shadow   = '{clcd_pkg::RST_PULSE, clcd_pkg::RST_SETTLE, clcd_pkg::RST_POWER,
                     clcd_pkg::RST_LONG, clcd_pkg::RST_INIT_ONE, clcd_pkg::RST_INIT_TWO};

    // typed rows rely on the reset register values
    dir_tab = '{
      '{'{clcd_pkg::MODE_CMD, 8'h00, 2'd0, 8'd0}, 1'b1, 4,
        {pin_state(1'b0, 4'h0, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h0, 1'b0, 17'd100, 1'b0),
         pin_state(1'b0, 4'h0, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h0, 1'b0, 17'd100, 1'b1)}},
      '{'{clcd_pkg::MODE_DATA, 8'hFF, 2'd3, 8'hFF}, 1'b1, 4,
        {pin_state(1'b1, 4'hF, 1'b1, 17'd10, 1'b0),
         pin_state(1'b1, 4'hF, 1'b0, 17'd100, 1'b0),
         pin_state(1'b1, 4'hF, 1'b1, 17'd10, 1'b0),
         pin_state(1'b1, 4'hF, 1'b0, 17'd100, 1'b1)}},
      '{'{clcd_pkg::MODE_HOME, 8'h00, 2'd0, 8'd0}, 1'b1, 4,
        {pin_state(1'b0, 4'h0, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h0, 1'b0, 17'd100, 1'b0),
         pin_state(1'b0, 4'h2, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h2, 1'b0, 17'd2100, 1'b1)}},
      '{'{clcd_pkg::MODE_CLEAR, 8'hFF, 2'd3, 8'hFF}, 1'b1, 4,
        {pin_state(1'b0, 4'h0, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h0, 1'b0, 17'd100, 1'b0),
         pin_state(1'b0, 4'h1, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'h1, 1'b0, 17'd2100, 1'b1)}},
      '{'{clcd_pkg::MODE_CURSOR, 8'h00, clcd_pkg::ROW_ONE, 8'd0}, 1'b1, 4,
        {pin_state(1'b0, 4'hF, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'hF, 1'b0, 17'd100, 1'b0),
         pin_state(1'b0, 4'hF, 1'b1, 17'd10, 1'b0),
         pin_state(1'b0, 4'hF, 1'b0, 17'd100, 1'b1)}},
      '{'{clcd_pkg::MODE_CURSOR, 8'h55, 2'd0, 8'd5}, 1'b1, 0, '0},
      '{'{clcd_pkg::MODE_CURSOR, 8'hAA, 2'd3, 8'd5}, 1'b1, 0, '0},
      '{'{MODE_SPARE_A, 8'hFF, clcd_pkg::ROW_ONE, 8'd1}, 1'b1, 0, '0},
      '{'{MODE_SPARE_B, 8'h00, clcd_pkg::ROW_TWO, 8'd2}, 1'b1, 0, '0},
      '{'{clcd_pkg::MODE_INIT, 8'h00, 2'd0, 8'd0}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CMD, 8'hFF, 2'd3, 8'hFF}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_DATA, 8'h00, 2'd0, 8'd0}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CURSOR, 8'h00, clcd_pkg::ROW_TWO, 8'd1}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CURSOR, 8'h00, clcd_pkg::ROW_ONE, 8'd255}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CURSOR, 8'h00, clcd_pkg::ROW_TWO, 8'd0}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CMD, clcd_pkg::BYTE_CLEAR, 2'd0, 8'd0}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CMD, clcd_pkg::BYTE_HOME, 2'd0, 8'd0}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_DATA, 8'hA5, 2'd1, 8'h5A}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_INIT, 8'hFF, 2'd3, 8'hFF}, 1'b0, 0, '0},
      '{'{clcd_pkg::MODE_CURSOR, 8'hFF, clcd_pkg::ROW_ONE, 8'd1}, 1'b0, 0, '0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].st, states);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pins();
      case (phase)
        0:       v = {6{16'hFFFF}};
        1:       v = '0;
        2:       v = {$urandom, $urandom, $urandom};
        3:       v = {$urandom, $urandom, $urandom} & {6{16'h003F}};
        default: v = '{clcd_pkg::RST_PULSE, clcd_pkg::RST_SETTLE, clcd_pkg::RST_POWER,
                       clcd_pkg::RST_LONG, clcd_pkg::RST_INIT_ONE,
                       clcd_pkg::RST_INIT_TWO};
      endcase
      write_regs(v);
      produced = 0;
      while (produced < ITEMS_PER_PHASE) begin
        r.byte_value = 8'($urandom);
        r.column     = 8'($urandom);
        r.row        = 2'($urandom);
        pick = $urandom_range(99);
        if (pick < 4) r.mode = clcd_pkg::MODE_INIT;
        else if (pick < 30) r.mode = clcd_pkg::MODE_CMD;
        else if (pick < 56) r.mode = clcd_pkg::MODE_DATA;
        else if (pick < 78) r.mode = clcd_pkg::MODE_CURSOR;
        else if (pick < 86) r.mode = clcd_pkg::MODE_HOME;
        else if (pick < 94) r.mode = clcd_pkg::MODE_CLEAR;
        else r.mode = pick[0] ? MODE_SPARE_A : MODE_SPARE_B;
        if (r.mode == clcd_pkg::MODE_CURSOR && $urandom_range(99) < 85) begin
          r.row = $urandom_range(1) ? clcd_pkg::ROW_ONE : clcd_pkg::ROW_TWO;
        end
        send_req(r, 1'b0, 0, '0, states);
        if (states > 0) produced++;
      end
    end

    drain_pins();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
